FILE: rtl/pphash_pkg.sv
// Shared constants and types of the polynomial prefix hash table.
`default_nettype none

package pphash_pkg;

  // Modulus of the hash and its double, used by the final reduction.
  localparam logic [29:0] HashPrime   = 30'd1000000007;
  localparam logic [31:0] HashPrime2x = 32'd2000000014;

  // Barrett constant floor(2^60 / P), computed at elaboration.
  localparam logic [30:0] BarrettMu = 31'((64'd1 << 60) / 64'd1000000007);

  // Base after reset and offset that turns a byte into a digit.
  localparam logic [29:0] DefaultBase = 30'd331;
  localparam logic [7:0]  DigitOffset = 8'd96;

  // Item modes.
  localparam logic ModeAppend = 1'b0;
  localparam logic ModeQuery  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/polynomial_prefix_hash_table.sv
// Polynomial prefix hash table: prefix hashes and base powers modulo 1000000007.
// One item is in work at a time: an input transfer is followed by the registered
// memory read and the four-stage modular multiplier, and a new item is taken only
// once the last result has moved to the output register. Synchronous active-low reset
// clears the length, restores the base to 331 and empties the pipeline; the
// memories need no clearing pass.
`default_nettype none

module polynomial_prefix_hash_table #(
  parameter  int unsigned MAX_LEN = 1024,
  localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // Configuration port.
  input  wire logic             cfg_wr_en,
  input  wire logic [29:0]      cfg_wr_data,
  // Input channel.
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_mode,
  input  wire logic             in_start_new,
  input  wire logic [7:0]       in_char_byte,
  input  wire logic [LEN_W-1:0] in_left_pos,
  input  wire logic [LEN_W-1:0] in_right_pos,
  // Result channel.
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [29:0]           out_hash_value,
  output logic [1:0]            out_status,
  output logic [LEN_W-1:0]      out_string_length
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_MUL  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t              state_r;
  logic [LEN_W-1:0]    len_r;
  logic [29:0]         base_r;
  logic                mode_r;
  pphash_pkg::status_t status_r;
  logic [LEN_W-1:0]    n_r;
  logic [29:0]         digit_r;
  logic                za_r, zb_r, zp_r;
  logic [29:0]         hrd_a_r, hrd_b_r, prd_r;
  logic [29:0]         res_hash_r;
  pphash_pkg::status_t res_status_r;
  logic [LEN_W-1:0]    res_len_r;
  logic                out_valid_r;
  logic [29:0]         out_hash_r;
  pphash_pkg::status_t out_status_r;
  logic [LEN_W-1:0]    out_len_r;

  // Memories; entry 0 of each is never written and reads as its fixed value.
  logic [29:0] hash_mem [MAX_LEN+1];
  logic [29:0] pow_mem  [MAX_LEN+1];

  logic             accept, commit;
  logic [LEN_W-1:0] n_eff, span, raddr_a, raddr_b, raddr_p, waddr;
  logic             q_ok, app_full;
  logic [29:0]      digit_nxt;
  logic [29:0]      h_a, h_b, p_v;
  logic [29:0]      mm0_a, mm0_b;
  logic             mm0_vld, mm1_vld;
  logic [29:0]      mm0_res, mm1_res;
  logic [30:0]      app_sum;
  logic [29:0]      hash_new, sub_hash;
  logic [29:0]      base_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state_r == S_MUL) && mm0_vld && mm1_vld;

  // Read addresses and item classification at the input transfer.
  always_comb begin
    n_eff    = (in_mode == pphash_pkg::ModeAppend && in_start_new) ? '0 : len_r;
    app_full = (n_eff == LEN_W'(MAX_LEN));
    q_ok     = (in_left_pos != '0) && (in_left_pos <= in_right_pos) &&
               (in_right_pos <= len_r);
    span     = in_right_pos - in_left_pos + LEN_W'(1);
    if (in_mode == pphash_pkg::ModeAppend) begin
      raddr_a = n_eff;
      raddr_b = n_eff;
      raddr_p = n_eff;
    end else if (q_ok) begin
      raddr_a = in_left_pos - LEN_W'(1);
      raddr_b = in_right_pos;
      raddr_p = span;
    end else begin
      raddr_a = '0;
      raddr_b = '0;
      raddr_p = '0;
    end
  end

  // Digit is byte minus 96, wrapped into [0, P) when negative.
  always_comb begin
    if (in_char_byte >= pphash_pkg::DigitOffset) begin
      digit_nxt = 30'(in_char_byte - pphash_pkg::DigitOffset);
    end else begin
      digit_nxt = pphash_pkg::HashPrime - 30'(pphash_pkg::DigitOffset - in_char_byte);
    end
  end

  // Base register holds the written value already reduced modulo P.
  assign base_nxt = (cfg_wr_data >= pphash_pkg::HashPrime) ?
                    cfg_wr_data - pphash_pkg::HashPrime : cfg_wr_data;

  // Memory read data with the fixed entry 0 substituted.
  assign h_a = za_r ? '0 : hrd_a_r;
  assign h_b = zb_r ? '0 : hrd_b_r;
  assign p_v = zp_r ? 30'd1 : prd_r;

  // Append multiplies hash and power by the base; a query multiplies the left
  // prefix hash by the power of the range length.
  assign mm0_a = h_a;
  assign mm0_b = (mode_r == pphash_pkg::ModeAppend) ? base_r : p_v;

  pphash_mulmod u_mul_hash (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (state_r == S_LOAD),
    .in_a       (mm0_a),
    .in_b       (mm0_b),
    .out_valid  (mm0_vld),
    .out_result (mm0_res)
  );

  pphash_mulmod u_mul_pow (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (state_r == S_LOAD),
    .in_a       (p_v),
    .in_b       (base_r),
    .out_valid  (mm1_vld),
    .out_result (mm1_res)
  );

  // New prefix hash and range hash, each one compare and subtract.
  always_comb begin
    app_sum  = 31'(mm0_res) + 31'(digit_r);
    hash_new = (app_sum >= 31'(pphash_pkg::HashPrime)) ?
               30'(app_sum - 31'(pphash_pkg::HashPrime)) : 30'(app_sum);
    sub_hash = (h_b >= mm0_res) ? h_b - mm0_res :
               30'(31'(h_b) + 31'(pphash_pkg::HashPrime) - 31'(mm0_res));
  end

  assign waddr = n_r + LEN_W'(1);

  // Memory write at commit of an append and registered reads at the input transfer.
  always_ff @(posedge clk) begin
    if (commit && mode_r == pphash_pkg::ModeAppend && status_r == pphash_pkg::ST_OK) begin
      hash_mem[waddr] <= hash_new;
      pow_mem[waddr]  <= mm1_res;
    end
    if (accept) begin
      hrd_a_r <= hash_mem[raddr_a];
      hrd_b_r <= hash_mem[raddr_b];
      prd_r   <= pow_mem[raddr_p];
    end
  end

  // Item fields captured at the input transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      n_r     <= n_eff;
      digit_r <= digit_nxt;
      za_r    <= (raddr_a == '0);
      zb_r    <= (raddr_b == '0);
      zp_r    <= (raddr_p == '0);
      if (in_mode == pphash_pkg::ModeAppend) begin
        status_r <= app_full ? pphash_pkg::ST_FULL : pphash_pkg::ST_OK;
      end else begin
        status_r <= q_ok ? pphash_pkg::ST_OK : pphash_pkg::ST_BAD_RANGE;
      end
    end
  end

  // Result held until the output register is free.
  always_ff @(posedge clk) begin
    if (commit) begin
      res_status_r <= status_r;
      if (mode_r == pphash_pkg::ModeAppend) begin
        if (status_r == pphash_pkg::ST_OK) begin
          res_hash_r <= hash_new;
          res_len_r  <= waddr;
        end else begin
          res_hash_r <= h_a;
          res_len_r  <= len_r;
        end
      end else begin
        res_hash_r <= (status_r == pphash_pkg::ST_OK) ? sub_hash : '0;
        res_len_r  <= len_r;
      end
    end
  end

  // Sequencer, stored length and base register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      base_r  <= pphash_pkg::DefaultBase;
    end else begin
      if (cfg_wr_en) begin
        base_r <= base_nxt;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (commit) begin
            state_r <= S_DONE;
            if (mode_r == pphash_pkg::ModeAppend && status_r == pphash_pkg::ST_OK) begin
              len_r <= waddr;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_hash_r   <= res_hash_r;
      out_status_r <= res_status_r;
      out_len_r    <= res_len_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hash_value    = out_hash_r;
  assign out_status        = out_status_r;
  assign out_string_length = out_len_r;

`ifndef ASSERT_OFF
  // Stored length never exceeds the capacity.
  assert property (@(posedge clk) disable iff (!rst_n) len_r <= LEN_W'(MAX_LEN))
    else $error("stored length beyond capacity");

  // Modular products are fully reduced.
  assert property (@(posedge clk) disable iff (!rst_n)
    mm0_vld |-> (mm0_res < pphash_pkg::HashPrime && mm1_res < pphash_pkg::HashPrime))
    else $error("modular product not reduced");

  // A stored append grows the string by exactly one character.
  assert property (@(posedge clk) disable iff (!rst_n)
    (commit && mode_r == pphash_pkg::ModeAppend && status_r == pphash_pkg::ST_OK)
    |=> len_r == $past(n_r) + LEN_W'(1))
    else $error("length not advanced after append");
`endif

endmodule

`default_nettype wire

FILE: rtl/pphash_mulmod.sv
// Four-stage pipelined modular multiplier (Barrett reduction modulo the hash prime).
`default_nettype none

module pphash_mulmod (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [29:0] in_a,
  input  wire logic [29:0] in_b,
  output logic             out_valid,
  output logic [29:0]      out_result
);

  logic        v1_r, v2_r, v3_r, v4_r;
  logic [59:0] prod_r;
  logic [61:0] qm_r;
  logic [31:0] xlo_r;
  logic [31:0] rem_r;
  logic [29:0] res_r;
  logic [30:0] q3;
  logic [31:0] qp;
  logic [29:0] res_nxt;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Quotient estimate times the prime; only the low 32 bits are needed since
  // the remainder stays below three times the prime.
  assign q3 = qm_r[61:31];
  assign qp = 32'(q3) * 32'(pphash_pkg::HashPrime);

  // Remainder is below 3P: subtract P once or twice.
  always_comb begin
    if (rem_r >= pphash_pkg::HashPrime2x) begin
      res_nxt = 30'(rem_r - pphash_pkg::HashPrime2x);
    end else if (rem_r >= 32'(pphash_pkg::HashPrime)) begin
      res_nxt = 30'(rem_r - 32'(pphash_pkg::HashPrime));
    end else begin
      res_nxt = rem_r[29:0];
    end
  end

  // Datapath stages: product, quotient estimate, remainder, final correction.
  always_ff @(posedge clk) begin
    prod_r <= 60'(in_a) * 60'(in_b);
    qm_r   <= 62'(prod_r[59:29]) * 62'(pphash_pkg::BarrettMu);
    xlo_r  <= prod_r[31:0];
    rem_r  <= xlo_r - qp;
    res_r  <= res_nxt;
  end

  assign out_valid  = v4_r;
  assign out_result = res_r;

endmodule

`default_nettype wire

FILE: tb/prefix_hash_sb_pkg.sv
// Scoreboard class that predicts and checks the results of the polynomial prefix hash table.
`timescale 1ns / 100ps

package prefix_hash_sb_pkg;
  import pphash_pkg::*;

  // Store depth used by the testbench; the block is built with the same value.
  localparam int unsigned MaxLen = 1024;
  localparam longint unsigned Prime = 64'd1000000007;

  // One request on the input channel.
  typedef struct packed {
    logic        mode;
    logic        start_new;
    logic [7:0]  char_code;
    logic [10:0] left_pos;
    logic [10:0] right_pos;
  } hash_request_t;

  // One result as the block should return it.
  typedef struct packed {
    logic [29:0] hash_value;
    status_t     status;
    logic [10:0] str_len;
  } hash_result_t;

  class prefix_hash_scoreboard;
    logic [29:0]  prefix_hash [MaxLen + 1];
    logic [29:0]  base_power [MaxLen + 1];
    int unsigned  str_len;
    logic [29:0]  base_reg;
    hash_result_t hash_results_q[$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  appends;
    int unsigned  full_appends;
    int unsigned  queries;
    int unsigned  bad_queries;
    int unsigned  base_writes;

    // State after reset: empty string, base 331.
    function new();
      foreach (prefix_hash[i]) begin
        prefix_hash[i] = '0;
        base_power[i] = '0;
      end
      base_power[0] = 30'd1;
      str_len = 0;
      base_reg = DefaultBase;
      mismatches = 0;
      checked = 0;
      appends = 0;
      full_appends = 0;
      queries = 0;
      bad_queries = 0;
      base_writes = 0;
    endfunction

    function void set_base(logic [29:0] value);
      base_reg = value;
      base_writes++;
    endfunction

    static function logic [29:0] mul_mod(logic [29:0] a, logic [29:0] b);
      longint unsigned product;
      product = 64'(a) * 64'(b);
      return 30'(product % Prime);
    endfunction

    function int unsigned pending();
      return hash_results_q.size();
    endfunction

    // Update the string state for an accepted transfer and queue its result.
    function void note_request(hash_request_t req);
      hash_result_t want;
      logic [29:0]  base_mod;
      logic [29:0]  digit;
      logic [29:0]  sub;
      int unsigned  n;
      int unsigned  l;
      int unsigned  r;
      base_mod = 30'(64'(base_reg) % Prime);
      l = req.left_pos;
      r = req.right_pos;
      want.status = ST_OK;
      want.hash_value = '0;
      if (req.mode == ModeAppend) begin
        appends++;
        if (req.start_new) str_len = 0;
        n = str_len;
        if (n >= MaxLen) begin
          // Full store: nothing is stored, the whole-string hash comes back.
          want.hash_value = prefix_hash[MaxLen];
          want.status = ST_FULL;
          full_appends++;
        end else begin
          // Bytes below the offset give negative digits, folded into [0, P).
          digit = 30'((64'(req.char_code) + Prime - 64'(DigitOffset)) % Prime);
          prefix_hash[n + 1] = 30'((64'(mul_mod(prefix_hash[n], base_mod)) + 64'(digit)) % Prime);
          base_power[n + 1] = mul_mod(base_power[n], base_mod);
          str_len = n + 1;
          want.hash_value = prefix_hash[n + 1];
        end
      end else begin
        queries++;
        if (l < 1 || l > r || r > str_len || r > MaxLen) begin
          want.status = ST_BAD_RANGE;
          bad_queries++;
        end else begin
          sub = mul_mod(prefix_hash[l - 1], base_power[r - l + 1]);
          want.hash_value = 30'((64'(prefix_hash[r]) + Prime - 64'(sub)) % Prime);
        end
      end
      want.str_len = 11'(str_len);
      hash_results_q = {hash_results_q, want};
    endfunction

    // Compare one result transfer with the oldest queued result.
    function void check_result(logic [29:0] hash_value, logic [1:0] status,
                               logic [10:0] len_out);
      hash_result_t want;
      if (hash_results_q.size() == 0) begin
        $display("%0t: unexpected result: hash %0d status %0d length %0d",
                 $time, hash_value, status, len_out);
        mismatches++;
        return;
      end
      want = hash_results_q.pop_front();
      checked++;
      if (hash_value !== want.hash_value) begin
        $display("%0t: hash_value expected %0d actual %0d", $time, want.hash_value, hash_value);
        mismatches++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        mismatches++;
      end
      if (len_out !== want.str_len) begin
        $display("%0t: string_length expected %0d actual %0d", $time, want.str_len, len_out);
        mismatches++;
      end
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
// Top-level testbench that drives and checks the polynomial prefix hash table.
`timescale 1ns / 100ps

module tb_top;
  import pphash_pkg::*;
  import prefix_hash_sb_pkg::*;

  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned TailCycles = 20;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [29:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = 1'b0;
  logic        in_start_new = 1'b0;
  logic [7:0]  in_char_byte = '0;
  logic [10:0] in_left_pos = '0;
  logic [10:0] in_right_pos = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [29:0] out_hash_value;
  logic [1:0]  out_status;
  logic [10:0] out_string_length;

  prefix_hash_scoreboard hash_sb = new();
  int unsigned burst_left = 0;
  int unsigned stuck_cycles = 0;
  int unsigned stall_timer = 0;
  int unsigned stall_style = 0;
  int unsigned stall_count = 0;

  polynomial_prefix_hash_table #(
    .MAX_LEN(MaxLen)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_start_new     (in_start_new),
    .in_char_byte     (in_char_byte),
    .in_left_pos      (in_left_pos),
    .in_right_pos     (in_right_pos),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hash_value   (out_hash_value),
    .out_status       (out_status),
    .out_string_length(out_string_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Present one request and hold it until the transfer; gaps fall between bursts.
  task automatic send_request(input hash_request_t req);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_mode <= req.mode;
    in_start_new <= req.start_new;
    in_char_byte <= req.char_code;
    in_left_pos <= req.left_pos;
    in_right_pos <= req.right_pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hash_sb.note_request(req);
    burst_left--;
  endtask

  // Stop sending and wait until every queued result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (hash_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_base(input logic [29:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    hash_sb.set_base(value);
  endtask

  // Mostly well-formed appends and in-range queries, with some broken ranges.
  function automatic hash_request_t random_request(int unsigned query_pct, int unsigned fresh_pm);
    hash_request_t req;
    int unsigned   len;
    int unsigned   r;
    len = hash_sb.str_len;
    req.char_code = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(97, 122))
                                                : 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) >= query_pct) begin
      req.mode = ModeAppend;
      req.start_new = ($urandom_range(0, 999) < fresh_pm);
      req.left_pos = 11'($urandom_range(0, 2047));
      req.right_pos = 11'($urandom_range(0, 2047));
    end else begin
      req.mode = ModeQuery;
      req.start_new = 1'($urandom_range(0, 1));
      if (len > 0 && $urandom_range(0, 99) < 85) begin
        r = $urandom_range(1, len);
        req.right_pos = 11'(r);
        req.left_pos = 11'($urandom_range(1, r));
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            req.left_pos = '0;
            req.right_pos = 11'($urandom_range(0, len));
          end
          1: begin
            r = $urandom_range(0, len);
            req.right_pos = 11'(r);
            req.left_pos = 11'(r + $urandom_range(1, 5));
          end
          2: begin
            r = $urandom_range(len + 1, 2047);
            req.right_pos = 11'(r);
            req.left_pos = 11'($urandom_range(1, r));
          end
          default: begin
            req.left_pos = 11'($urandom_range(0, 2047));
            req.right_pos = 11'($urandom_range(0, 2047));
          end
        endcase
      end
    end
    return req;
  endfunction

  task automatic random_phase(int unsigned count, int unsigned query_pct, int unsigned fresh_pm);
    repeat (count) send_request(random_request(query_pct, fresh_pm));
  endtask

  // Receiver back-pressure: a stall style is picked for each stretch of cycles.
  always @(negedge clk) begin
    if (stall_timer == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_timer = $urandom_range(20, 80);
    end else begin
      stall_timer = stall_timer - 1;
    end
    stall_count = stall_count + 1;
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (stall_count % 5) != 0;
    endcase
  end

  // Check every result transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      hash_sb.check_result(out_hash_value, out_status, out_string_length);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StuckLimit);
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset base: empty string, digit extremes, bad ranges.
    send_request('{ModeQuery, 1'b0, 8'd0, 11'd1, 11'd1});
    send_request('{ModeQuery, 1'b0, 8'd0, 11'd0, 11'd0});
    send_request('{ModeAppend, 1'b1, 8'd97, 11'd0, 11'd0});
    send_request('{ModeAppend, 1'b0, 8'd0, 11'd2047, 11'd2047});
    send_request('{ModeAppend, 1'b0, 8'd95, 11'd0, 11'd0});
    send_request('{ModeAppend, 1'b0, 8'd96, 11'd0, 11'd0});
    send_request('{ModeAppend, 1'b0, 8'd255, 11'd1024, 11'd1});
    // A query with start_new set must leave the string alone.
    send_request('{ModeQuery, 1'b1, 8'd255, 11'd1, 11'd5});
    send_request('{ModeQuery, 1'b0, 8'd0, 11'd5, 11'd5});
    send_request('{ModeQuery, 1'b0, 8'd0, 11'd2, 11'd4});
    send_request('{ModeQuery, 1'b0, 8'd0, 11'd3, 11'd2});
    send_request('{ModeQuery, 1'b0, 8'd0, 11'd2, 11'd6});
    send_request('{ModeQuery, 1'b0, 8'd0, 11'd0, 11'd5});
    send_request('{ModeQuery, 1'b0, 8'd0, 11'd2047, 11'd2047});
    send_request('{ModeQuery, 1'b0, 8'd0, 11'd1024, 11'd2047});
    send_request('{ModeAppend, 1'b1, 8'd122, 11'd0, 11'd0});
    send_request('{ModeQuery, 1'b0, 8'd0, 11'd1, 11'd1});
    send_request('{ModeAppend, 1'b0, 8'd98, 11'd0, 11'd0});
    send_request('{ModeAppend, 1'b0, 8'd99, 11'd0, 11'd0});
    send_request('{ModeQuery, 1'b0, 8'd0, 11'd2, 11'd3});

    // Random phases under several bases; the string carries over between them.
    drain();
    write_base(30'd2);
    random_phase(30, 35, 20);
    drain();
    write_base(30'd1000000006);
    random_phase(30, 40, 10);
    drain();
    write_base(30'd0);
    random_phase(20, 40, 30);
    drain();
    write_base(30'd1);
    random_phase(20, 40, 30);
    drain();
    write_base(30'h3FFFFFFF);
    random_phase(20, 40, 20);
    drain();
    write_base(30'd1000000007);
    random_phase(20, 40, 20);

    // Grow one string until the store is full, then hit it with appends and queries.
    drain();
    write_base(30'($urandom_range(2, 1000000006)));
    send_request('{ModeAppend, 1'b1, 8'd97, 11'd0, 11'd0});
    while (hash_sb.str_len < MaxLen) send_request(random_request(2, 0));
    random_phase(4, 0, 0);
    send_request('{ModeQuery, 1'b0, 8'd0, 11'd1, 11'd1024});
    send_request('{ModeQuery, 1'b0, 8'd0, 11'd1024, 11'd1024});
    send_request('{ModeQuery, 1'b0, 8'd0, 11'd1, 11'd1025});
    send_request('{ModeQuery, 1'b0, 8'd0, 11'd512, 11'd1024});
    random_phase(20, 60, 0);
    send_request('{ModeAppend, 1'b1, 8'd120, 11'd0, 11'd0});

    drain();
    write_base(DefaultBase);
    random_phase(40, 40, 20);
    drain();
    repeat (TailCycles) @(posedge clk);

    $display("Run covered %0d appends (%0d on a full store) and %0d queries (%0d out of range),",
             hash_sb.appends, hash_sb.full_appends, hash_sb.queries, hash_sb.bad_queries);
    $display("under %0d base settings, with %0d results checked.",
             hash_sb.base_writes, hash_sb.checked);
    if (hash_sb.mismatches == 0 && hash_sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
